// ----- hw/rtl/stack_machine_execute_unit_core_assert.svh -----
// Assertion macros shared by the stack machine execute unit.
`ifndef STACK_MACHINE_EXECUTE_UNIT_CORE_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SMEU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smeu: same-cycle invariant violated");

// Next-cycle implication, disabled while reset is held.
`define SMEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smeu: next-cycle invariant violated");

`endif

// ----- hw/rtl/smeu_pkg.sv -----
// Types and constants shared by the stack machine execute unit.
`timescale 1ns / 1ps

package smeu_pkg;

    typedef enum logic [4:0] {
        K_HALT  = 5'd0,  K_PUSHC = 5'd1,  K_ADD   = 5'd2,  K_SUB   = 5'd3,
        K_MUL   = 5'd4,  K_DIV   = 5'd5,  K_MOD   = 5'd6,  K_RDINT = 5'd7,
        K_WRINT = 5'd8,  K_RDCHR = 5'd9,  K_WRCHR = 5'd10, K_PUSHG = 5'd11,
        K_POPG  = 5'd12, K_ASF   = 5'd13, K_RSF   = 5'd14, K_PUSHL = 5'd15,
        K_POPL  = 5'd16, K_EQ    = 5'd17, K_NE    = 5'd18, K_LT    = 5'd19,
        K_LE    = 5'd20, K_GT    = 5'd21, K_GE    = 5'd22, K_JMP   = 5'd23,
        K_BRF   = 5'd24, K_BRT   = 5'd25
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_OVER   = 3'd1,
        ST_UNDER  = 3'd2,
        ST_DIV0   = 3'd3,
        ST_GLOBAL = 3'd4,
        ST_LOCAL  = 3'd5
    } t_status;

    // Decoded instruction as it sits in the queue.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] imm;
        logic [31:0] val;   // value to push for pushc, rdint and rdchr
    } t_cmd;

    typedef struct packed {
        logic        wv;
        logic [31:0] wval;
        logic        wch;
        logic        bt;
        logic [30:0] btar;
        logic        hl;
        t_status     status;
    } t_result;

endpackage

// ----- hw/rtl/smeu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module smeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hw/rtl/smeu_div.sv -----
// Radix-2 signed divider, truncating toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps

module smeu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dv;
    logic        r_nq;
    logic        r_nr;
    logic [32:0] w_trial;

    assign w_trial = {r_rem[31:0], r_quo[31]} - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_a[31] ? (32'd0 - i_a) : i_a;
            r_dv  <= i_b[31] ? (32'd0 - i_b) : i_b;
            r_nq  <= i_a[31] ^ i_b[31];
            r_nr  <= i_a[31];
        end else if (r_busy && r_cnt != '0) begin
            if (!w_trial[32]) begin
                r_rem <= w_trial;
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_quo[31]};
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_nq ? (32'd0 - r_quo) : r_quo;
    assign o_rem  = r_nr ? (32'd0 - r_rem[31:0]) : r_rem[31:0];

endmodule

// ----- hw/rtl/smeu_front.sv -----
// Front end: accepts instructions, decodes the push value and queues them.
`timescale 1ns / 1ps

module smeu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tvalid,
    output logic          o_tready,
    input  logic [63:0]   i_tdata,    // immediate [31:0], read_value [63:32]
    input  logic [4:0]    i_tuser,    // kind [4:0]
    output logic          o_cmd_valid,
    output smeu_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import smeu_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    always_comb begin
        w_cmd.kind = t_kind'(i_tuser);
        w_cmd.imm  = i_tdata[31:0];
        case (w_cmd.kind)
            K_RDINT: w_cmd.val = i_tdata[63:32];
            K_RDCHR: w_cmd.val = {24'd0, i_tdata[39:32]};
            default: w_cmd.val = i_tdata[31:0];
        endcase
    end

    assign o_tready    = (r_cnt != 2'd2);
    assign w_push      = i_tvalid && o_tready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !i_cmd_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && i_cmd_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// ----- hw/rtl/smeu_exec.sv -----
// Back end: sequences stack and global memory accesses for one instruction.
`timescale 1ns / 1ps

module smeu_exec #(
    parameter int STACK_DEPTH  = 1024,
    parameter int GLOBAL_COUNT = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  smeu_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_res_valid,
    output smeu_pkg::t_result o_res,
    input  logic              i_res_ready
);
    import smeu_pkg::*;

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SPW  = $clog2(STACK_DEPTH + 1);
    localparam int GW   = (GLOBAL_COUNT > 1) ? $clog2(GLOBAL_COUNT) : 1;
    localparam int MAXD = (STACK_DEPTH > GLOBAL_COUNT) ? STACK_DEPTH : GLOBAL_COUNT;
    localparam int CLW  = $clog2(MAXD + 1);

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_CHK  = 6'b000100,
        S_RA   = 6'b001000,
        S_RB   = 6'b010000,
        S_DIV  = 6'b100000
    } t_state;

    t_state         r_state, n_state;
    logic [SPW-1:0] r_sp, n_sp;
    logic [SPW-1:0] r_fp, n_fp;
    logic [31:0]    r_b, n_b;
    logic [CLW-1:0] r_clr, n_clr;
    t_result        r_res, n_res;
    logic           r_res_valid, n_res_valid;
    t_cmd           r_cmd;

    logic           s_we, g_we;
    logic [AW-1:0]  s_waddr, s_raddr;
    logic [GW-1:0]  g_waddr, g_raddr;
    logic [31:0]    s_wdata, g_wdata;
    logic [31:0]    w_s_rdata, w_g_rdata;

    logic           div_start, div_done;
    logic [31:0]    div_quo, div_rem;

    logic           fin;
    t_result        fin_res;

    logic [SPW-1:0] sp_m1, sp_m2, fp_m1;
    logic           sp_full, sp_lt1, sp_lt2, glob_bad, slot_bad, asf_over;
    logic [32:0]    slot, asf_end;
    logic [31:0]    w_alu;
    logic           w_taken;

    function automatic logic f_cmp(input t_kind k, input logic signed [31:0] a,
                                   input logic signed [31:0] b);
        logic r;
        case (k)
            K_EQ:    r = (a == b);
            K_NE:    r = (a != b);
            K_LT:    r = (a < b);
            K_LE:    r = (a <= b);
            K_GT:    r = (a > b);
            default: r = (a >= b);
        endcase
        return r;
    endfunction

    smeu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(w_s_rdata)
    );

    smeu_ram #(.WIDTH(32), .DEPTH(GLOBAL_COUNT)) u_glob (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(g_raddr), .o_rdata(w_g_rdata)
    );

    smeu_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_a(w_s_rdata), .i_b(r_b),
        .o_done(div_done), .o_quo(div_quo), .o_rem(div_rem)
    );

    assign sp_m1    = r_sp - SPW'(1);
    assign sp_m2    = r_sp - SPW'(2);
    assign fp_m1    = r_fp - SPW'(1);
    assign sp_full  = (r_sp == SPW'(STACK_DEPTH));
    assign sp_lt1   = (r_sp == '0);
    assign sp_lt2   = (r_sp < SPW'(2));
    assign glob_bad = r_cmd.imm[31] | ({1'b0, r_cmd.imm[30:0]} >= 32'(GLOBAL_COUNT));
    assign slot     = 33'(r_fp) + {r_cmd.imm[31], r_cmd.imm};
    assign slot_bad = slot[32] | (slot[31:0] >= 32'(STACK_DEPTH));
    assign asf_end  = 33'(r_sp) + 33'(r_cmd.imm[30:0]) + 33'd1;
    assign asf_over = (asf_end > 33'(STACK_DEPTH));
    assign w_taken  = ((r_cmd.kind == K_BRF) && (w_s_rdata == 32'd0)) ||
                      ((r_cmd.kind == K_BRT) && (w_s_rdata == 32'd1));

    always_comb begin
        case (r_cmd.kind)
            K_ADD:   w_alu = w_s_rdata + r_b;
            K_SUB:   w_alu = w_s_rdata - r_b;
            K_MUL:   w_alu = w_s_rdata * r_b;
            default: w_alu = {31'd0, f_cmp(r_cmd.kind, w_s_rdata, r_b)};
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_fp        = r_fp;
        n_b         = r_b;
        n_clr       = r_clr;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_ready;
        o_cmd_pop   = 1'b0;
        div_start   = 1'b0;
        s_we        = 1'b0;
        s_waddr     = r_sp[AW-1:0];
        s_wdata     = w_s_rdata;
        s_raddr     = sp_m1[AW-1:0];
        g_we        = 1'b0;
        g_waddr     = r_cmd.imm[GW-1:0];
        g_wdata     = w_s_rdata;
        g_raddr     = r_cmd.imm[GW-1:0];
        fin         = 1'b0;
        fin_res     = '0;

        unique case (r_state)
            S_CLR: begin
                s_we    = (r_clr < CLW'(STACK_DEPTH));
                s_waddr = r_clr[AW-1:0];
                s_wdata = '0;
                g_we    = (r_clr < CLW'(GLOBAL_COUNT));
                g_waddr = r_clr[GW-1:0];
                g_wdata = '0;
                n_clr   = r_clr + CLW'(1);
                if (r_clr == CLW'(MAXD - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && !r_res_valid) begin
                    o_cmd_pop = 1'b1;
                    n_state   = S_CHK;
                end
            end
            S_CHK: begin
                unique case (r_cmd.kind) inside
                    K_HALT: begin
                        fin        = 1'b1;
                        fin_res.hl = 1'b1;
                    end
                    K_PUSHC, K_RDINT, K_RDCHR: begin
                        fin = 1'b1;
                        if (sp_full) begin
                            fin_res.status = ST_OVER;
                        end else begin
                            s_we    = 1'b1;
                            s_wdata = r_cmd.val;
                            n_sp    = r_sp + SPW'(1);
                        end
                    end
                    K_ADD, K_SUB, K_MUL, K_DIV, K_MOD,
                    K_EQ, K_NE, K_LT, K_LE, K_GT, K_GE: begin
                        if (sp_lt2) begin
                            fin            = 1'b1;
                            fin_res.status = ST_UNDER;
                        end else begin
                            n_state = S_RA;
                        end
                    end
                    K_WRINT, K_WRCHR, K_BRF, K_BRT: begin
                        if (sp_lt1) begin
                            fin            = 1'b1;
                            fin_res.status = ST_UNDER;
                        end else begin
                            n_state = S_RA;
                        end
                    end
                    K_PUSHG: begin
                        if (sp_full) begin
                            fin            = 1'b1;
                            fin_res.status = ST_OVER;
                        end else if (glob_bad) begin
                            fin            = 1'b1;
                            fin_res.status = ST_GLOBAL;
                        end else begin
                            n_state = S_RA;
                        end
                    end
                    K_POPG: begin
                        if (sp_lt1) begin
                            fin            = 1'b1;
                            fin_res.status = ST_UNDER;
                        end else if (glob_bad) begin
                            fin            = 1'b1;
                            fin_res.status = ST_GLOBAL;
                        end else begin
                            n_state = S_RA;
                        end
                    end
                    K_ASF: begin
                        fin = 1'b1;
                        if (sp_full) begin
                            fin_res.status = ST_OVER;
                        end else if (r_cmd.imm[31]) begin
                            fin_res.status = ST_UNDER;
                        end else if (asf_over) begin
                            fin_res.status = ST_OVER;
                        end else begin
                            s_we    = 1'b1;
                            s_wdata = 32'(r_fp);
                            n_fp    = r_sp + SPW'(1);
                            n_sp    = asf_end[SPW-1:0];
                        end
                    end
                    K_RSF: begin
                        s_raddr = fp_m1[AW-1:0];
                        if (r_fp == '0) begin
                            fin            = 1'b1;
                            fin_res.status = ST_UNDER;
                        end else begin
                            n_state = S_RA;
                        end
                    end
                    K_PUSHL: begin
                        s_raddr = slot[AW-1:0];
                        if (sp_full) begin
                            fin            = 1'b1;
                            fin_res.status = ST_OVER;
                        end else if (slot_bad) begin
                            fin            = 1'b1;
                            fin_res.status = ST_LOCAL;
                        end else begin
                            n_state = S_RA;
                        end
                    end
                    K_POPL: begin
                        if (sp_lt1) begin
                            fin            = 1'b1;
                            fin_res.status = ST_UNDER;
                        end else if (slot_bad) begin
                            fin            = 1'b1;
                            fin_res.status = ST_LOCAL;
                        end else begin
                            n_state = S_RA;
                        end
                    end
                    K_JMP: begin
                        fin          = 1'b1;
                        fin_res.bt   = 1'b1;
                        fin_res.btar = r_cmd.imm[30:0];
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_RA: begin
                unique case (r_cmd.kind) inside
                    K_ADD, K_SUB, K_MUL, K_DIV, K_MOD,
                    K_EQ, K_NE, K_LT, K_LE, K_GT, K_GE: begin
                        // Top of stack is the right operand; fetch the left one next.
                        n_b     = w_s_rdata;
                        s_raddr = sp_m2[AW-1:0];
                        if ((r_cmd.kind == K_DIV || r_cmd.kind == K_MOD) &&
                            w_s_rdata == 32'd0) begin
                            fin            = 1'b1;
                            fin_res.status = ST_DIV0;
                        end else begin
                            n_state = S_RB;
                        end
                    end
                    K_WRINT, K_WRCHR: begin
                        fin          = 1'b1;
                        fin_res.wv   = 1'b1;
                        fin_res.wval = w_s_rdata;
                        fin_res.wch  = (r_cmd.kind == K_WRCHR);
                        n_sp         = sp_m1;
                    end
                    K_BRF, K_BRT: begin
                        fin          = 1'b1;
                        fin_res.bt   = w_taken;
                        fin_res.btar = w_taken ? r_cmd.imm[30:0] : 31'd0;
                        n_sp         = sp_m1;
                    end
                    K_POPG: begin
                        fin  = 1'b1;
                        g_we = 1'b1;
                        n_sp = sp_m1;
                    end
                    K_PUSHG: begin
                        fin     = 1'b1;
                        s_we    = 1'b1;
                        s_wdata = w_g_rdata;
                        n_sp    = r_sp + SPW'(1);
                    end
                    K_RSF: begin
                        fin = 1'b1;
                        if (w_s_rdata > 32'(STACK_DEPTH)) begin
                            fin_res.status = ST_LOCAL;
                        end else begin
                            n_sp = fp_m1;
                            n_fp = w_s_rdata[SPW-1:0];
                        end
                    end
                    K_PUSHL: begin
                        fin  = 1'b1;
                        s_we = 1'b1;
                        n_sp = r_sp + SPW'(1);
                    end
                    K_POPL: begin
                        fin     = 1'b1;
                        s_we    = 1'b1;
                        s_waddr = slot[AW-1:0];
                        n_sp    = sp_m1;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_RB: begin
                if (r_cmd.kind == K_DIV || r_cmd.kind == K_MOD) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    fin     = 1'b1;
                    s_we    = 1'b1;
                    s_waddr = sp_m2[AW-1:0];
                    s_wdata = w_alu;
                    n_sp    = sp_m1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    fin     = 1'b1;
                    s_we    = 1'b1;
                    s_waddr = sp_m2[AW-1:0];
                    s_wdata = (r_cmd.kind == K_MOD) ? div_rem : div_quo;
                    n_sp    = sp_m1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_res       = fin_res;
            n_res_valid = 1'b1;
            n_state     = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_sp        <= '0;
            r_fp        <= '0;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_fp        <= n_fp;
            r_clr       <= n_clr;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b   <= n_b;
        r_res <= n_res;
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- hw/rtl/stack_machine_execute_unit_core.sv -----
// Top level of the stack machine execute unit: front queue, back end, port packing.
`timescale 1ns / 1ps

// The execute unit runs one decoded instruction per input transfer against an
// operand stack, a frame pointer and a global data area, and returns exactly one
// result transfer per instruction. The program counter lives outside: branches
// only report whether they are taken and where to.
// Input channel: tuser carries the opcode, tdata the immediate and read value.
// Output channel: tdata carries the print, branch, halt and status fields, and
// tuser marks a printed value as a character.
// A two-entry queue decouples the input from the back end, so the source may
// keep sending while an instruction executes. The steps of the back end from
// pickup to result are set by the registered read of the stack memory (binary
// operators read it twice); div and mod also wait for the radix-2 divider.
// The next instruction is picked up once the result has been taken, so only one
// instruction is in the back end at a time. After reset the block clears both
// memories, one entry per cycle; inputs are queued but not executed then.
// When the receiver stalls, the result is held and the next queued instruction
// waits until it has been taken.
module stack_machine_execute_unit_core #(
    parameter int STACK_DEPTH  = 1024,
    parameter int GLOBAL_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [63:0] i_tdata,    // immediate [31:0], read_value [63:32]
    input  logic [4:0]  i_tuser,    // kind [4:0]
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [71:0] o_tdata,    // write_valid [0], write_value [32:1],
                                    // branch_taken [33], branch_target [64:34],
                                    // halted [65], status [68:66], zero [71:69]
    output logic [0:0]  o_tuser     // write_is_char [0]
);
    import smeu_pkg::*;

    `include "stack_machine_execute_unit_core_assert.svh"

    logic    w_cmd_valid;
    logic    w_cmd_pop;
    t_cmd    w_cmd;
    t_result w_res;

    // Front end: accept, decode the push value, queue.
    smeu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tvalid   (i_tvalid),
        .o_tready   (o_tready),
        .i_tdata    (i_tdata),
        .i_tuser    (i_tuser),
        .o_cmd_valid(w_cmd_valid),
        .o_cmd      (w_cmd),
        .i_cmd_pop  (w_cmd_pop)
    );

    // Back end: stack checks, memory sequencing, divider, result register.
    smeu_exec #(
        .STACK_DEPTH (STACK_DEPTH),
        .GLOBAL_COUNT(GLOBAL_COUNT)
    ) u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .o_res_valid(o_tvalid),
        .o_res      (w_res),
        .i_res_ready(i_tready)
    );

    assign o_tdata = {3'd0, w_res.status, w_res.hl, w_res.btar, w_res.bt,
                      w_res.wval, w_res.wv};
    assign o_tuser = w_res.wch;

    // An error result carries nothing but its status code.
    `SMEU_ASSERT_IMPL(a_err_clean, i_clk, i_rst_n, o_tvalid && (o_tdata[68:66] != ST_OK), (o_tdata[65:0] == 66'd0) && (o_tuser == 1'b0))
    // A full queue always has an instruction waiting for the back end.
    `SMEU_ASSERT_IMPL(a_full_has_cmd, i_clk, i_rst_n, !o_tready, w_cmd_valid)
    // The back end takes one instruction at a time.
    `SMEU_ASSERT_NEXT(a_single_pop, i_clk, i_rst_n, w_cmd_pop, !w_cmd_pop)

endmodule
